// ----- hw/rtl/record_stream_parser_defines.svh -----
// Assertion macros for the record stream parser.
// Included by the top level; needs nothing else.
`ifndef RECORD_STREAM_PARSER_DEFINES_SVH
`define RECORD_STREAM_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record_stream_parser: assertion failed");
`define RSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record_stream_parser: assertion failed");
`else
`define RSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/rsp_pkg.sv -----
// Types and constants shared by the record stream parser modules.
// Depends on nothing.
`default_nettype none

package rsp_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 32;
    localparam int SIZE_W     = 64;
    localparam int NUM_FIELDS = 4;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_LEN  = 2'd1,
        PH_SIZE = 2'd2,
        PH_STR  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_STRING = 2'd1,
        KIND_TRUNC  = 2'd2
    } t_kind;

    typedef logic [NUM_FIELDS-1:0][LEN_W-1:0] t_lengths;

    typedef struct packed {
        t_kind              kind;
        logic [LEN_W-1:0]   name_length;
        logic [LEN_W-1:0]   uri_length;
        logic [LEN_W-1:0]   path_length;
        logic [LEN_W-1:0]   hash_length;
        logic [SIZE_W-1:0]  resource_size;
        logic [1:0]         field_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               last_of_field;
        logic               last_of_record;
    } t_result;

    // First field at or after 'from' whose length flag is set; bit 2 set when none.
    function automatic logic [2:0] next_field(logic [NUM_FIELDS-1:0] nz, logic [2:0] from);
        logic [2:0] res;
        res = 3'b100;
        for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
            if (nz[i] && (3'(i) >= from)) begin
                res = {1'b0, 2'(i)};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rsp_parser.sv -----
// Record parse state and the single-pass next-state and result logic.
// Depends on rsp_pkg.
`default_nettype none

module rsp_parser (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  wire  [rsp_pkg::BYTE_W-1:0]   i_byte,
    input  wire                          i_last,
    output logic                         o_emit,
    output rsp_pkg::t_result             o_result
);
    import rsp_pkg::*;

    t_phase                 r_phase,       n_phase;
    logic [BYTE_W-1:0]      r_size_codes,  n_size_codes;
    logic [2:0]             r_cnt,         n_cnt;
    logic [1:0]             r_cur,         n_cur;
    t_lengths               r_len,         n_len;
    logic [SIZE_W-1:0]      r_size,        n_size;
    logic [LEN_W-1:0]       r_remaining,   n_remaining;

    logic [1:0]             w_code;
    logic [1:0]             w_last_idx;
    logic [NUM_FIELDS-1:0]  w_nz;
    logic [2:0]             w_first;
    logic [2:0]             w_after;
    logic                   w_rec_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG;
            r_size_codes <= '0;
            r_cnt        <= '0;
            r_cur        <= '0;
            r_len        <= '0;
            r_size       <= '0;
            r_remaining  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_size_codes <= n_size_codes;
            r_cnt        <= n_cnt;
            r_cur        <= n_cur;
            r_len        <= n_len;
            r_size       <= n_size;
            r_remaining  <= n_remaining;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            w_nz[i] = (r_len[i] != '0);
        end
        w_first = next_field(w_nz, 3'd0);
        w_after = next_field(w_nz, {1'b0, r_cur} + 3'd1);
        unique case (r_cur)
            2'd0:    w_code = r_size_codes[7:6];
            2'd1:    w_code = r_size_codes[5:4];
            2'd2:    w_code = r_size_codes[3:2];
            default: w_code = r_size_codes[1:0];
        endcase
        unique case (w_code)
            2'd0:    w_last_idx = 2'd0;
            2'd1:    w_last_idx = 2'd1;
            default: w_last_idx = 2'd3;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_size_codes = r_size_codes;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_len        = r_len;
        n_size       = r_size;
        n_remaining  = r_remaining;
        o_emit       = 1'b0;
        o_result     = '0;
        w_rec_end    = 1'b0;

        if (i_step) begin
            unique case (r_phase)
                PH_FLAG: begin
                    n_size_codes = i_byte;
                    n_len        = '0;
                    n_size       = '0;
                    n_cur        = 2'd0;
                    n_cnt        = 3'd0;
                    n_phase      = PH_LEN;
                end
                PH_LEN: begin
                    n_len[r_cur][{r_cnt[1:0], 3'b000} +: BYTE_W] = i_byte;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt[1:0] >= w_last_idx) begin
                        n_cnt = 3'd0;
                        if (r_cur == 2'd3) begin
                            n_cur   = 2'd0;
                            n_phase = PH_SIZE;
                        end else begin
                            n_cur = r_cur + 2'd1;
                        end
                    end
                end
                PH_SIZE: begin
                    n_size[{r_cnt, 3'b000} +: BYTE_W] = i_byte;
                    if (r_cnt == 3'd7) begin
                        n_cnt                  = 3'd0;
                        o_emit                 = 1'b1;
                        o_result.kind          = KIND_HEADER;
                        o_result.name_length   = r_len[0];
                        o_result.uri_length    = r_len[1];
                        o_result.path_length   = r_len[2];
                        o_result.hash_length   = r_len[3];
                        o_result.resource_size = n_size;
                        if (w_first[2]) begin
                            w_rec_end               = 1'b1;
                            o_result.last_of_record = 1'b1;
                            n_phase                 = PH_FLAG;
                            n_cur                   = 2'd0;
                            n_remaining             = '0;
                        end else begin
                            n_cur       = w_first[1:0];
                            n_remaining = r_len[w_first[1:0]];
                            n_phase     = PH_STR;
                        end
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                default: begin
                    o_emit               = 1'b1;
                    o_result.kind        = KIND_STRING;
                    o_result.field_index = r_cur;
                    o_result.data_byte   = i_byte;
                    n_remaining          = r_remaining - LEN_W'(1);
                    if (r_remaining == LEN_W'(1)) begin
                        o_result.last_of_field = 1'b1;
                        if (w_after[2]) begin
                            w_rec_end               = 1'b1;
                            o_result.last_of_record = 1'b1;
                            n_phase                 = PH_FLAG;
                            n_cnt                   = 3'd0;
                            n_cur                   = 2'd0;
                            n_remaining             = '0;
                        end else begin
                            n_cur       = w_after[1:0];
                            n_remaining = r_len[w_after[1:0]];
                        end
                    end
                end
            endcase

            if (i_last && !w_rec_end) begin
                o_emit        = 1'b1;
                o_result      = '0;
                o_result.kind = KIND_TRUNC;
                n_phase       = PH_FLAG;
                n_cnt         = 3'd0;
                n_cur         = 2'd0;
                n_remaining   = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rsp_out_reg.sv -----
// Result register between the parse logic and the output stream.
// Depends on rsp_pkg.
`default_nettype none

module rsp_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_emit,
    input  rsp_pkg::t_result    i_result,
    input  wire                 i_ready,
    output logic                o_free,
    output logic                o_valid,
    output rsp_pkg::t_result    o_result
);
    import rsp_pkg::*;

    logic     r_valid;
    t_result  r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/record_stream_parser.sv -----
// Top level of the record stream parser: input register, parser, result register.
// Depends on rsp_pkg, rsp_parser, rsp_out_reg and record_stream_parser_defines.svh.
`default_nettype none

// Takes one byte of a packed record buffer per item and returns a header item
// after each record's size field, one item per string byte, and a truncation
// item when the buffer's last byte falls inside a record. One byte is accepted
// every cycle while the output does not stall; an item passes an input register
// and then a result register. The parse of one byte is a single pass of logic
// between those two registers. Back-pressure on the output stalls both stages;
// the input side keeps taking a byte while the input register is empty.
module record_stream_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // byte_value
    input  wire          s_axis_tlast,   // last_of_buffer
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // name_length, uri_length, path_length, hash_length, resource_size, data_byte
    output logic [199:0] m_axis_tdata,
    output logic [7:0]   m_axis_tuser,   // kind, field_index, last_of_field, zero fill
    output logic         m_axis_tlast    // last_of_record
);
    import rsp_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;
    logic               w_advance;
    logic               w_emit;
    t_result            w_result;
    t_result            w_out;

    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    rsp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    rsp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (w_emit),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_free   (w_advance),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out)
    );

    assign m_axis_tdata = {w_out.data_byte, w_out.resource_size, w_out.hash_length,
                           w_out.path_length, w_out.uri_length, w_out.name_length};
    assign m_axis_tuser = {3'b000, w_out.last_of_field, w_out.field_index, w_out.kind};
    assign m_axis_tlast = w_out.last_of_record;

`include "record_stream_parser_defines.svh"

    `RSP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
    `RSP_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `RSP_ASSERT_IMP(a_trunc_not_end, i_clk, i_rst_n, m_axis_tvalid && (w_out.kind == KIND_TRUNC), !m_axis_tlast && !w_out.last_of_field)

endmodule

`default_nettype wire

// ----- tb/sv/record_stream_parser_checker.sv -----
`timescale 1ns / 100ps
// Result checker for record_stream_parser: watches the byte and result streams,
// predicts every result from the accepted bytes and compares it field by field.
// Depends on rsp_pkg for the phase, result kind and result struct types.
module record_stream_parser_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [7:0]   i_s_tdata,    // byte_value
    input  wire          i_s_tlast,    // last_of_buffer
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    // name_length, uri_length, path_length, hash_length, resource_size, data_byte
    input  wire  [199:0] i_m_tdata,
    input  wire  [7:0]   i_m_tuser,    // kind, field_index, last_of_field, zero fill
    input  wire          i_m_tlast,    // last_of_record
    output int           o_fail_count,
    output int           o_pending
);
    import rsp_pkg::*;

    t_phase        rec_phase;
    logic [7:0]    size_codes;
    logic [2:0]    byte_cnt;
    logic [1:0]    cur_field;
    logic [31:0]   field_len [4];
    logic [63:0]   size_acc;
    logic [31:0]   str_left;
    t_result       parsed_q [$];
    t_result       want;
    int            mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int len_bytes(logic [1:0] f);
        logic [1:0] code;
        code = 2'(size_codes >> (6 - 2 * int'(f)));
        if (code == 2'd0) return 1;
        if (code == 2'd1) return 2;
        return 4;
    endfunction

    function automatic int first_filled(int from);
        for (int i = from; i < 4; i++) begin
            if (field_len[i] != 32'd0) return i;
        end
        return 4;
    endfunction

    task automatic rewind();
        rec_phase = PH_FLAG;
        byte_cnt  = 3'd0;
        cur_field = 2'd0;
        str_left  = 32'd0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last_buf);
        t_result r;
        bit      emit;
        bit      rec_end;
        int      nf;
        r       = '0;
        emit    = 1'b0;
        rec_end = 1'b0;
        case (rec_phase)
            PH_FLAG: begin
                size_codes = b;
                for (int i = 0; i < 4; i++) field_len[i] = 32'd0;
                size_acc  = 64'd0;
                cur_field = 2'd0;
                byte_cnt  = 3'd0;
                rec_phase = PH_LEN;
            end
            PH_LEN: begin
                field_len[cur_field] |= 32'(b) << (8 * int'(byte_cnt[1:0]));
                byte_cnt = byte_cnt + 3'd1;
                if (int'(byte_cnt) >= len_bytes(cur_field)) begin
                    byte_cnt = 3'd0;
                    if (cur_field == 2'd3) begin
                        cur_field = 2'd0;
                        rec_phase = PH_SIZE;
                    end else begin
                        cur_field = cur_field + 2'd1;
                    end
                end
            end
            PH_SIZE: begin
                size_acc |= 64'(b) << (8 * int'(byte_cnt));
                if (byte_cnt == 3'd7) begin
                    byte_cnt        = 3'd0;
                    emit            = 1'b1;
                    r.kind          = KIND_HEADER;
                    r.name_length   = field_len[0];
                    r.uri_length    = field_len[1];
                    r.path_length   = field_len[2];
                    r.hash_length   = field_len[3];
                    r.resource_size = size_acc;
                    nf = first_filled(0);
                    if (nf >= 4) begin
                        rec_end          = 1'b1;
                        r.last_of_record = 1'b1;
                        rewind();
                    end else begin
                        cur_field = 2'(nf);
                        str_left  = field_len[nf];
                        rec_phase = PH_STR;
                    end
                end else begin
                    byte_cnt = byte_cnt + 3'd1;
                end
            end
            default: begin
                emit          = 1'b1;
                r.kind        = KIND_STRING;
                r.field_index = cur_field;
                r.data_byte   = b;
                str_left      = str_left - 32'd1;
                if (str_left == 32'd0) begin
                    r.last_of_field = 1'b1;
                    nf = first_filled(int'(cur_field) + 1);
                    if (nf >= 4) begin
                        rec_end          = 1'b1;
                        r.last_of_record = 1'b1;
                        rewind();
                    end else begin
                        cur_field = 2'(nf);
                        str_left  = field_len[nf];
                    end
                end
            end
        endcase
        if (last_buf && !rec_end) begin
            r      = '0;
            r.kind = KIND_TRUNC;
            emit   = 1'b1;
            rewind();
        end
        if (emit) parsed_q = {parsed_q, r};
    endtask

    task automatic cmp(input string fname, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rewind();
            size_codes = 8'd0;
            for (int i = 0; i < 4; i++) field_len[i] = 32'd0;
            size_acc = 64'd0;
            parsed_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (parsed_q.size() == 0) begin
                    $error("unexpected result item: tuser 0x%0h", i_m_tuser);
                    mismatches++;
                end else begin
                    want = parsed_q.pop_front();
                    cmp("kind",           64'(want.kind),           64'(i_m_tuser[1:0]));
                    cmp("name_length",    64'(want.name_length),    64'(i_m_tdata[31:0]));
                    cmp("uri_length",     64'(want.uri_length),     64'(i_m_tdata[63:32]));
                    cmp("path_length",    64'(want.path_length),    64'(i_m_tdata[95:64]));
                    cmp("hash_length",    64'(want.hash_length),    64'(i_m_tdata[127:96]));
                    cmp("resource_size",  want.resource_size,       i_m_tdata[191:128]);
                    cmp("field_index",    64'(want.field_index),    64'(i_m_tuser[3:2]));
                    cmp("data_byte",      64'(want.data_byte),      64'(i_m_tdata[199:192]));
                    cmp("last_of_field",  64'(want.last_of_field),  64'(i_m_tuser[4]));
                    cmp("last_of_record", 64'(want.last_of_record), 64'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready) parse_byte(i_s_tdata, i_s_tlast);
        end
        o_pending = parsed_q.size();
    end

endmodule

// ----- tb/sv/record_stream_parser_test.sv -----
`timescale 1ns / 100ps
// Top of the record_stream_parser testbench: clock, reset, byte buffers of packed
// records and noise, random idling on both sides. Needs the RTL and the checker.
module record_stream_parser_test;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'd0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [199:0] m_axis_tdata;
    logic [7:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int           fail_count;
    int           pending;
    int           items_sent = 0;
    int           send_idle  = 0;
    int           stall_pct  = 0;
    int           hold_len   = 0;
    int           hold_seq   = 0;
    int           hold_seen  = 0;
    int           hold_left  = 0;
    logic [7:0]   stream_bytes [$];

    always #10 i_clk = ~i_clk;

    record_stream_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    record_stream_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // hold off for a requested stretch, else stall at random
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen     <= hold_seq;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++) begin
            send_item(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        stream_bytes.delete();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        stream_bytes = {stream_bytes, b};
    endtask

    // append one record; a random full-range length marks it big, and a big record keeps at most 8 string bytes
    task automatic add_record(output bit big);
        logic [7:0]  flags;
        logic [31:0] lens [4];
        logic [63:0] size;
        logic [1:0]  code;
        int          w [4];
        int          limit;
        int          pushed;
        flags = 8'($urandom);
        big   = 1'b0;
        for (int f = 0; f < 4; f++) begin
            code = 2'(flags >> (6 - 2 * f));
            w[f] = (code == 2'd0) ? 1 : (code == 2'd1) ? 2 : 4;
            if ($urandom_range(2) == 0) begin
                lens[f] = 32'd0;
            end else if ($urandom_range(29) == 0) begin
                lens[f] = $urandom;
                if (w[f] < 4) lens[f] &= (32'd1 << (8 * w[f])) - 32'd1;
                big = 1'b1;
            end else begin
                lens[f] = $urandom_range(6, 1);
            end
        end
        size = {$urandom, $urandom};
        put_byte(flags);
        for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < w[f]; k++) put_byte(lens[f][8*k +: 8]);
        end
        for (int k = 0; k < 8; k++) put_byte(size[8*k +: 8]);
        limit  = big ? $urandom_range(8) : 32'h7fffffff;
        pushed = 0;
        for (int f = 0; f < 4; f++) begin
            for (int i = 0; i < lens[f] && pushed < limit; i++) begin
                put_byte(8'($urandom));
                pushed++;
            end
        end
    endtask

    task automatic send_buffer(input int n_records, input bit cut);
        int start;
        bit big;
        big   = 1'b0;
        start = 0;
        for (int r = 0; r < n_records && !big; r++) begin
            start = stream_bytes.size();
            add_record(big);
        end
        if (cut && !big && stream_bytes.size() - start > 1) begin
            stream_bytes = stream_bytes[0 : start
                + $urandom_range(stream_bytes.size() - start - 1, 1) - 1];
        end
        send_stream();
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) send_item(8'($urandom), i == n - 1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flag byte alone at the buffer end
        stream_bytes = '{8'hA5};
        send_stream();
        // empty record ending at its header, then a header cut as strings start
        stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                         8'h1B, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                         8'h02, 8'h00, 8'h00, 8'h00,
                         8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
        send_stream();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  stall_pct <= 0;  end
                1: begin send_idle = 73; stall_pct <= 0;  end
                2: begin send_idle = 0;  stall_pct <= 73; end
                default: begin send_idle = 11; stall_pct <= 11; end
            endcase
            if (ph == 0) begin
                hold_len <= 400;
                hold_seq <= hold_seq + 1;
            end
            while (items_sent < 34 + (ph + 1) * 175) begin
                if ($urandom_range(9) == 0) send_noise();
                else send_buffer($urandom_range(3, 1), $urandom_range(3) == 0);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- record_stream_parser.f -----
+incdir+hw/rtl
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_parser.sv
hw/rtl/rsp_out_reg.sv
hw/rtl/record_stream_parser.sv
tb/sv/record_stream_parser_checker.sv
tb/sv/record_stream_parser_test.sv
